// ===== rtl/csr_spike_current_scatter_defines.svh =====
// ----------------------------------------------------------------------------
// csr_spike_current_scatter assertion macros
// Assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CSR_SPIKE_CURRENT_SCATTER_DEFINES_SVH
`define CSR_SPIKE_CURRENT_SCATTER_DEFINES_SVH
`ifndef SYNTH
`define CSC_ASSERT(lbl, prop, clk, rst) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error("assert failed");
`define CSC_ASSERT_NEVER(lbl, expr, clk, rst) \
  lbl: assert property (@(posedge clk) disable iff (!rst) !(expr)) else $error("never failed");
`else
`define CSC_ASSERT(lbl, prop, clk, rst)
`define CSC_ASSERT_NEVER(lbl, expr, clk, rst)
`endif
`endif

// ===== rtl/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants of the spike current scatter block.
// ----------------------------------------------------------------------------
package csc_pkg;
  localparam logic [2:0] REQ_EDGE  = 3'd0;
  localparam logic [2:0] REQ_ROW   = 3'd1;
  localparam logic [2:0] REQ_BASIS = 3'd2;
  localparam logic [2:0] REQ_SPIKE = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_RNG = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request fields
    logic wr_edge;
    logic wr_row;
    logic wr_basis;
    logic rd_row0;   // read row start [pre]
    logic rd_row1;   // read row start [pre+1]
    logic rd_edge;   // read edge at cursor
    logic mul_ws;    // spike * weight
    logic rd_cur;    // read current + basis for receptor
    logic mul_v;     // ws * basis
    logic wr_cur;    // add and write back
    logic next_rec;
    logic next_edge;
    logic rd_req;    // read current for read request
    logic clr_step;
    logic clr_init;
  } csc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic edge_done;  // cursor reached end
    logic edge_oob;   // cursor beyond edge store, or sum saturated on write-back
    logic edge_bad;
    logic rec_last;
    logic clr_last;
  } csc_sts_t;
endpackage

// ===== rtl/csr_spike_current_scatter.sv =====
// ----------------------------------------------------------------------------
// csr_spike_current_scatter
// Event-driven sparse synaptic current scatter over CSR tables.
// ----------------------------------------------------------------------------
// Usage: drive a request on the field ports and raise start while busy is
// low; the request is taken at that edge. One result beat follows with
// strobe_o high for one cycle carrying read_value_o and status_o; busy stays
// high through that cycle. A spike walks the row of its pre index and does
// one read-modify-write of the shared current memory port per valid edge
// and active receptor; edges with an out-of-range target or type are skipped.
// A clear request sweeps the whole current memory, one word per cycle.
// After reset the currents are cleared in the same way before the first
// request is taken. Configuration writes are accepted any time.
// The receiver cannot stall; each result beat is shown exactly once.
// ----------------------------------------------------------------------------
`include "csr_spike_current_scatter_defines.svh"
module csr_spike_current_scatter #(
  parameter int EDGES = 4096,
  parameter int PRE   = 1024,
  parameter int POST  = 1024,
  parameter int BASIS = 4,
  parameter int TYPES = 8,
  parameter int BATCH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         req_type_i,
  input  logic [11:0]        edge_index_i,
  input  logic [10:0]        pre_index_i,
  input  logic [9:0]         post_index_i,
  input  logic [2:0]         syn_type_i,
  input  logic [1:0]         receptor_i,
  input  logic [1:0]         batch_index_i,
  input  logic [12:0]        row_start_i,
  input  logic signed [15:0] weight_value_i,
  input  logic signed [15:0] spike_value_i,
  input  logic signed [15:0] basis_value_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [10:0]        cfg_data_i,
  output logic               strobe_o,
  output logic signed [31:0] read_value_o,
  output logic [1:0]         status_o
);
  import csc_pkg::*;

  localparam logic [1:0] CFG_PRE   = 2'd0;
  localparam logic [1:0] CFG_POST  = 2'd1;
  localparam logic [1:0] CFG_BASIS = 2'd2;

  logic [10:0] act_pre_q, act_post_q;
  logic [2:0]  act_basis_q;

  csc_cmd_t cmd;
  csc_sts_t sts, sts_c;
  logic     sat, done, rd_sel, ctrl_busy, go;
  logic [1:0] st;
  logic signed [31:0] rd_data;
  logic     wr_ok, rd_ok, spike_go, spike_rng;
  logic     init_q;
  csc_cmd_t cmd_dp;

  function automatic logic [10:0] clampv(logic [10:0] v, logic [10:0] hi);
    logic [10:0] r;
    r = v;
    if (v == '0) r = 11'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_pre_q   <= 11'(PRE);
      act_post_q  <= 11'(POST);
      act_basis_q <= 3'(BASIS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRE:   act_pre_q   <= clampv(cfg_data_i, 11'(PRE));
        CFG_POST:  act_post_q  <= clampv(cfg_data_i, 11'(POST));
        CFG_BASIS: act_basis_q <= 3'(clampv({8'd0, cfg_data_i[2:0]}, 11'(BASIS)));
        default: ;
      endcase
    end
  end

  always_comb begin
    case (req_type_i)
      REQ_EDGE:  wr_ok = 32'(edge_index_i) < EDGES;
      REQ_ROW:   wr_ok = pre_index_i <= act_pre_q;
      REQ_BASIS: wr_ok = (32'(syn_type_i) < TYPES) && (3'(receptor_i) < act_basis_q);
      default:   wr_ok = 1'b0;
    endcase
  end
  assign rd_ok = (32'(batch_index_i) < BATCH) && (11'(post_index_i) < act_post_q) &&
                 (3'(receptor_i) < act_basis_q);
  assign spike_rng = (spike_value_i > 0) &&
                     ((32'(batch_index_i) >= BATCH) || (pre_index_i >= act_pre_q));
  assign spike_go  = (spike_value_i > 0) && !spike_rng;

  // reset clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) init_q <= 1'b1;
    else if (init_q && sts.clr_last) init_q <= 1'b0;
  end

  assign go = start && !busy;
  assign sts_c = sts;

  always_comb begin
    cmd_dp = cmd;
    if (init_q) cmd_dp.clr_step = 1'b1;
  end

  csc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start(go && !init_q), .req_type_i,
    .spike_go_i(spike_go), .spike_rng_i(spike_rng), .wr_ok_i(wr_ok),
    .rd_ok_i(rd_ok), .sts_i(sts_c), .cmd_o(cmd), .busy(ctrl_busy),
    .done_o(done), .rd_sel_o(rd_sel), .status_o(st)
  );

  csc_dp #(.EDGES(EDGES), .PRE(PRE), .POST(POST), .BASIS(BASIS), .TYPES(TYPES),
           .BATCH(BATCH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd_dp), .edge_index_i, .pre_index_i, .post_index_i,
    .syn_type_i, .receptor_i, .batch_index_i, .row_start_i, .weight_value_i,
    .spike_value_i, .basis_value_i, .active_post_i(act_post_q),
    .active_basis_i(act_basis_q), .sts_o(sts), .sat_o(sat), .rd_data_o(rd_data)
  );

  assign busy         = ctrl_busy || init_q;
  assign strobe_o     = done;
  assign read_value_o = (done && rd_sel) ? rd_data : 32'sd0;
  assign status_o     = st;

  `CSC_ASSERT(a_no_start_init, init_q |-> !cmd.load, clk_i, rst_ni)
  `CSC_ASSERT(a_strobe_single, strobe_o |=> !strobe_o, clk_i, rst_ni)
  `CSC_ASSERT_NEVER(a_sat_code, sat && !cmd.wr_cur, clk_i, rst_ni)
  `CSC_ASSERT_NEVER(a_status_code, strobe_o && status_o == 2'd3, clk_i, rst_ni)
endmodule

// ===== rtl/csc_ctrl.sv =====
// ----------------------------------------------------------------------------
// csc_ctrl
// Sequencer for table writes, spike fan-out, reads and clears.
// ----------------------------------------------------------------------------
module csc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [2:0]        req_type_i,
  input  logic              spike_go_i,
  input  logic              spike_rng_i,
  input  logic              wr_ok_i,
  input  logic              rd_ok_i,
  input  csc_pkg::csc_sts_t sts_i,
  output csc_pkg::csc_cmd_t cmd_o,
  output logic              busy,
  output logic              done_o,
  output logic              rd_sel_o,
  output logic [1:0]        status_o
);
  import csc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ROW0, S_ROW1, S_EDGE, S_CHK, S_MUL, S_RCUR, S_MULV, S_WCUR,
    S_READ, S_CLR, S_DONE
  } state_e;

  state_e     state_q;
  logic [1:0] st_q;
  logic       rd_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == S_IDLE) && start;
    if (state_q == S_IDLE && start) begin
      cmd_o.wr_edge  = (req_type_i == REQ_EDGE) && wr_ok_i;
      cmd_o.wr_row   = (req_type_i == REQ_ROW) && wr_ok_i;
      cmd_o.wr_basis = (req_type_i == REQ_BASIS) && wr_ok_i;
      cmd_o.clr_init = (req_type_i == REQ_CLEAR);
    end
    case (state_q)
      S_ROW0: cmd_o.rd_row0 = 1'b1;
      S_ROW1: cmd_o.rd_row1 = 1'b1;
      S_EDGE: cmd_o.rd_edge = 1'b1;
      S_CHK:  if (!sts_i.edge_done && !sts_i.edge_oob && sts_i.edge_bad)
                cmd_o.next_edge = 1'b1;
      S_MUL:  cmd_o.mul_ws = 1'b1;
      S_RCUR: cmd_o.rd_cur = 1'b1;
      S_MULV: cmd_o.mul_v = 1'b1;
      S_WCUR: begin
        cmd_o.wr_cur = 1'b1;
        if (sts_i.rec_last) cmd_o.next_edge = 1'b1;
        else cmd_o.next_rec = 1'b1;
      end
      S_READ: cmd_o.rd_req = 1'b1;
      S_CLR:  cmd_o.clr_step = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
      rd_q    <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: if (start) begin
          rd_q <= (req_type_i == REQ_READ) && rd_ok_i;
          case (req_type_i)
            REQ_EDGE, REQ_ROW, REQ_BASIS: begin
              st_q    <= wr_ok_i ? ST_OK : ST_RNG;
              state_q <= S_DONE;
            end
            REQ_SPIKE: begin
              st_q    <= spike_rng_i ? ST_RNG : ST_OK;
              state_q <= spike_go_i ? S_ROW0 : S_DONE;
            end
            REQ_READ: begin
              st_q    <= rd_ok_i ? ST_OK : ST_RNG;
              state_q <= rd_ok_i ? S_READ : S_DONE;
            end
            REQ_CLEAR: begin
              st_q    <= ST_OK;
              state_q <= S_CLR;
            end
            default: begin
              st_q    <= ST_RNG;
              state_q <= S_DONE;
            end
          endcase
        end
        S_ROW0: state_q <= S_ROW1;
        S_ROW1: state_q <= S_EDGE;
        S_EDGE: state_q <= S_CHK;
        S_CHK: begin
          if (sts_i.edge_done) state_q <= S_DONE;
          else if (sts_i.edge_oob) begin
            if (st_q == ST_OK) st_q <= ST_RNG;
            state_q <= S_DONE;
          end else if (sts_i.edge_bad) begin
            if (st_q == ST_OK) st_q <= ST_RNG;
            state_q <= S_EDGE;
          end else state_q <= S_MUL;
        end
        S_MUL:  state_q <= S_RCUR;
        S_RCUR: state_q <= S_MULV;
        S_MULV: state_q <= S_WCUR;
        S_WCUR: begin
          if (sts_i.rec_last) state_q <= S_EDGE;
          else state_q <= S_RCUR;
        end
        S_READ: state_q <= S_DONE;
        S_CLR:  if (sts_i.clr_last) state_q <= S_DONE;
        S_DONE: begin
          done_o  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_WCUR && sts_i.edge_oob) st_q <= ST_SAT;
    end
  end

  assign busy     = (state_q != S_IDLE) || done_o;
  assign status_o = st_q;
  assign rd_sel_o = rd_q;
endmodule

// ===== rtl/csc_dp.sv =====
// ----------------------------------------------------------------------------
// csc_dp
// Table memories, current memory, multipliers and saturating accumulate.
// ----------------------------------------------------------------------------
module csc_dp #(
  parameter int EDGES = 4096,
  parameter int PRE   = 1024,
  parameter int POST  = 1024,
  parameter int BASIS = 4,
  parameter int TYPES = 8,
  parameter int BATCH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csc_pkg::csc_cmd_t   cmd_i,
  input  logic [11:0]         edge_index_i,
  input  logic [10:0]         pre_index_i,
  input  logic [9:0]          post_index_i,
  input  logic [2:0]          syn_type_i,
  input  logic [1:0]          receptor_i,
  input  logic [1:0]          batch_index_i,
  input  logic [12:0]         row_start_i,
  input  logic signed [15:0]  weight_value_i,
  input  logic signed [15:0]  spike_value_i,
  input  logic signed [15:0]  basis_value_i,
  input  logic [10:0]         active_post_i,
  input  logic [2:0]          active_basis_i,
  output csc_pkg::csc_sts_t   sts_o,
  output logic                sat_o,
  output logic signed [31:0]  rd_data_o
);
  import csc_pkg::*;

  localparam int EW  = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int PW  = $clog2(PRE + 1);
  localparam int BW  = (BASIS > 1) ? $clog2(BASIS) : 1;
  localparam int TW  = (TYPES > 1) ? $clog2(TYPES) : 1;
  localparam int BAW = (TYPES * BASIS > 1) ? $clog2(TYPES * BASIS) : 1;
  localparam int CD  = BATCH * POST * BASIS;
  localparam int CW  = (CD > 1) ? $clog2(CD) : 1;

  logic [9:0]         tgt_mem [EDGES];
  logic [2:0]         kind_mem [EDGES];
  logic signed [15:0] wgt_mem [EDGES];
  logic [12:0]        row_mem [PRE+1];
  logic signed [15:0] bas_mem [TYPES*BASIS];
  logic signed [31:0] cur_mem [CD];

  logic [1:0]         bat_q;
  logic [10:0]        pre_q;
  logic signed [15:0] spk_q;
  logic [12:0]        cur_e_q, end_q;
  logic [9:0]         tgt_q;
  logic [2:0]         kind_q;
  logic signed [15:0] w_q, bas_q;
  logic signed [23:0] ws_q;
  logic signed [31:0] v_q, acc_q;
  logic [1:0]         rec_q;
  logic [CW-1:0]      clr_q;
  logic [CW-1:0]      caddr;
  logic signed [31:0] rd_q;
  logic signed [39:0] prod_v;
  logic signed [32:0] sum;
  logic signed [31:0] sum_sat;

  // current memory address for spike path (post index) or read
  always_comb begin
    if (cmd_i.rd_req)
      caddr = CW'(((32'(bat_q) * POST) + 32'(tgt_q)) * BASIS + 32'(rec_q));
    else
      caddr = CW'(((32'(bat_q) * POST) + 32'(tgt_q)) * BASIS + 32'(rec_q));
  end

  assign prod_v = 40'(ws_q) * 40'(bas_q);
  assign sum = 33'(acc_q) + 33'(v_q);
  always_comb begin
    sum_sat = sum[31:0];
    if (sum > 33'sd2147483647) sum_sat = 32'sh7fffffff;
    else if (sum < -33'sd2147483648) sum_sat = 32'sh80000000;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_edge) begin
      tgt_mem[edge_index_i[EW-1:0]]  <= post_index_i;
      kind_mem[edge_index_i[EW-1:0]] <= syn_type_i;
      wgt_mem[edge_index_i[EW-1:0]]  <= weight_value_i;
    end
    if (cmd_i.wr_row) row_mem[pre_index_i[PW-1:0]] <= row_start_i;
    if (cmd_i.wr_basis)
      bas_mem[BAW'(syn_type_i[TW-1:0] * BASIS + receptor_i[BW-1:0])] <= basis_value_i;
    if (cmd_i.load) begin
      bat_q <= batch_index_i;
      pre_q <= pre_index_i;
      spk_q <= spike_value_i;
      tgt_q <= post_index_i;
      rec_q <= receptor_i;
    end
    if (cmd_i.rd_row0) begin
      cur_e_q <= row_mem[pre_q[PW-1:0]];
      rec_q   <= '0;
    end
    if (cmd_i.rd_row1) end_q <= row_mem[PW'(pre_q + 11'd1)];
    if (cmd_i.rd_edge) begin
      tgt_q  <= tgt_mem[cur_e_q[EW-1:0]];
      kind_q <= kind_mem[cur_e_q[EW-1:0]];
      w_q    <= wgt_mem[cur_e_q[EW-1:0]];
    end
    if (cmd_i.mul_ws) ws_q <= 24'((32'(spk_q) * 32'(w_q)) >>> 8);
    if (cmd_i.rd_cur) begin
      acc_q <= cur_mem[caddr];
      bas_q <= bas_mem[BAW'(kind_q[TW-1:0] * BASIS + rec_q[BW-1:0])];
    end
    if (cmd_i.mul_v) v_q <= 32'(prod_v >>> 8);
    if (cmd_i.wr_cur) cur_mem[caddr] <= sum_sat;
    if (cmd_i.next_rec) rec_q <= rec_q + 2'd1;
    if (cmd_i.next_edge) begin
      cur_e_q <= cur_e_q + 13'd1;
      rec_q   <= '0;
    end
    if (cmd_i.rd_req) rd_q <= cur_mem[caddr];
    if (cmd_i.clr_step) cur_mem[clr_q] <= '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_init) clr_q <= '0;
    else if (cmd_i.clr_step) clr_q <= clr_q + CW'(1);
  end

  assign sts_o.edge_done = !(cur_e_q < end_q);
  assign sts_o.edge_oob  = cmd_i.wr_cur ? (sum != 33'(sum_sat))
                                        : (32'(cur_e_q) >= EDGES);
  assign sts_o.edge_bad  = (11'(tgt_q) >= active_post_i) || (32'(kind_q) >= TYPES);
  assign sts_o.rec_last  = (3'(rec_q) + 3'd1 >= active_basis_i);
  assign sts_o.clr_last  = (32'(clr_q) == CD - 1);
  assign sat_o     = cmd_i.wr_cur && (sum != 33'(sum_sat));
  assign rd_data_o = rd_q;
endmodule

// ===== tb/tb_csr_spike_current_scatter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_csr_spike_current_scatter
// Self-checking bench for the CSR spike current scatter block. Requests are
// predicted by a local copy of the tables and currents and queued for a
// clocked driver; a monitor compares every result beat with the oldest
// prediction. Phases walk the active range registers through their extremes.
// ----------------------------------------------------------------------------
module tb_csr_spike_current_scatter;
  import csc_pkg::*;

  localparam int N_EDGES = 4096;
  localparam int N_PRE   = 1024;
  localparam int N_POST  = 1024;
  localparam int N_BASIS = 4;
  localparam int N_TYPES = 8;
  localparam int MAX_ROW = 24;
  localparam int LIMIT   = 4000000;
  localparam int PER_PHASE = 305;

  localparam logic [1:0] CFG_ACTIVE_PRE   = 2'd0;
  localparam logic [1:0] CFG_ACTIVE_POST  = 2'd1;
  localparam logic [1:0] CFG_ACTIVE_BASIS = 2'd2;
  localparam logic [2:0] REQ_BAD6 = 3'd6;
  localparam logic [2:0] REQ_BAD7 = 3'd7;

  typedef struct {
    logic [2:0]         req;
    logic [11:0]        eidx;
    logic [10:0]        pre;
    logic [9:0]         post;
    logic [2:0]         styp;
    logic [1:0]         rec;
    logic [1:0]         bat;
    logic [12:0]        rs;
    logic signed [15:0] w;
    logic signed [15:0] s;
    logic signed [15:0] b;
    logic signed [31:0] exp_val;
    logic [1:0]         exp_st;
  } req_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] req_type_i = '0;
  logic [11:0] edge_index_i = '0;
  logic [10:0] pre_index_i = '0;
  logic [9:0] post_index_i = '0;
  logic [2:0] syn_type_i = '0;
  logic [1:0] receptor_i = '0;
  logic [1:0] batch_index_i = '0;
  logic [12:0] row_start_i = '0;
  logic signed [15:0] weight_value_i = '0;
  logic signed [15:0] spike_value_i = '0;
  logic signed [15:0] basis_value_i = '0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic strobe_o;
  logic signed [31:0] read_value_o;
  logic [1:0] status_o;

  csr_spike_current_scatter u_dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  int unsigned act_pre = N_PRE, act_post = N_POST, act_basis = N_BASIS;
  logic [9:0] tgt_mem [N_EDGES];
  logic [2:0] kind_mem [N_EDGES];
  logic signed [15:0] weight_mem [N_EDGES];
  bit edge_set [N_EDGES];
  logic [12:0] row_mem [N_PRE+1];
  bit row_set [N_PRE+1];
  logic signed [15:0] basis_mem [N_TYPES*N_BASIS];
  bit basis_set [N_TYPES*N_BASIS];
  int current_mem [4*N_POST*N_BASIS];

  req_beat_t request_q[$];
  req_beat_t expected_q[$];
  req_beat_t active_req, nxt;
  int gap_left = 0;
  bit calm = 1'b0;
  bit idle_on = 1'b1;
  int errors = 0, n_beats = 0, n_spikes = 0, n_sat = 0, n_results = 0;
  int cycles = 0;

  function automatic bit spike_reads_written(req_beat_t it);
    int first, last, e, r;
    if (it.s <= 0 || it.pre >= act_pre) return 1'b1;
    if (!row_set[it.pre] || !row_set[it.pre+1]) return 1'b0;
    first = row_mem[it.pre];
    last = row_mem[it.pre+1];
    if (last - first > MAX_ROW) return 1'b0;
    for (e = first; e < last; e++) begin
      if (e >= N_EDGES) break;
      if (!edge_set[e]) return 1'b0;
      if (tgt_mem[e] >= act_post) continue;
      for (r = 0; r < act_basis; r++)
        if (!basis_set[kind_mem[e]*N_BASIS+r]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_scatter(inout req_beat_t it);
    int first, last, e, r, ci;
    longint ws, v, sum;
    it.exp_val = '0;
    it.exp_st = ST_OK;
    case (it.req)
      REQ_EDGE: begin
        tgt_mem[it.eidx] = it.post;
        kind_mem[it.eidx] = it.styp;
        weight_mem[it.eidx] = it.w;
        edge_set[it.eidx] = 1'b1;
      end
      REQ_ROW: begin
        if (it.pre > act_pre) it.exp_st = ST_RNG;
        else begin
          row_mem[it.pre] = it.rs;
          row_set[it.pre] = 1'b1;
        end
      end
      REQ_BASIS: begin
        if (it.rec >= act_basis) it.exp_st = ST_RNG;
        else begin
          basis_mem[it.styp*N_BASIS+it.rec] = it.b;
          basis_set[it.styp*N_BASIS+it.rec] = 1'b1;
        end
      end
      REQ_SPIKE: begin
        n_spikes++;
        if (it.s > 0) begin
          if (it.pre >= act_pre) it.exp_st = ST_RNG;
          else begin
            first = row_mem[it.pre];
            last = row_mem[it.pre+1];
            for (e = first; e < last; e++) begin
              if (e >= N_EDGES) begin
                if (it.exp_st == ST_OK) it.exp_st = ST_RNG;
                break;
              end
              if (tgt_mem[e] >= act_post) begin
                if (it.exp_st == ST_OK) it.exp_st = ST_RNG;
                continue;
              end
              ws = (longint'(it.s) * longint'(weight_mem[e])) >>> 8;
              for (r = 0; r < act_basis; r++) begin
                ci = (it.bat*N_POST + tgt_mem[e])*N_BASIS + r;
                v = (ws * longint'(basis_mem[kind_mem[e]*N_BASIS+r])) >>> 8;
                sum = longint'(current_mem[ci]) + v;
                if (sum > 64'sd2147483647) begin
                  sum = 64'sd2147483647;
                  it.exp_st = ST_SAT;
                end else if (sum < -64'sd2147483648) begin
                  sum = -64'sd2147483648;
                  it.exp_st = ST_SAT;
                end
                current_mem[ci] = int'(sum);
              end
            end
          end
        end
        if (it.exp_st == ST_SAT) n_sat++;
      end
      REQ_READ: begin
        if (it.post >= act_post || it.rec >= act_basis) it.exp_st = ST_RNG;
        else it.exp_val = current_mem[(it.bat*N_POST + it.post)*N_BASIS + it.rec];
      end
      REQ_CLEAR: foreach (current_mem[i]) current_mem[i] = 0;
      default: it.exp_st = ST_RNG;
    endcase
  endtask

  task automatic queue_request(req_beat_t it);
    predict_scatter(it);
    request_q.push_back(it);
  endtask

  task automatic dir(logic [2:0] req, int eidx, int pre, int post, int styp, int rec,
                     int bat, int rs, int w, int s, int b);
    req_beat_t it;
    it.req = req; it.eidx = eidx; it.pre = pre; it.post = post; it.styp = styp;
    it.rec = rec; it.bat = bat; it.rs = rs; it.w = w; it.s = s; it.b = b;
    queue_request(it);
  endtask

  function automatic int pick_index(int span, int cap);
    int top;
    top = (span < cap) ? span : cap;
    return $urandom_range(0, top - 1);
  endfunction

  task automatic gen_random();
    req_beat_t it;
    int k;
    bit ok;
    ok = 1'b0;
    while (!ok) begin
      it.eidx = $urandom; it.pre = $urandom; it.post = $urandom; it.styp = $urandom;
      it.rec = $urandom; it.bat = $urandom; it.rs = $urandom;
      it.w = $urandom; it.s = $urandom; it.b = $urandom;
      ok = 1'b1;
      k = $urandom_range(0, 999);
      if (k < 150) begin
        it.req = REQ_EDGE;
        k = $urandom_range(0, 9);
        if (k < 7) it.eidx = $urandom_range(0, 135);
        else if (k < 8) it.eidx = $urandom_range(4088, 4095);
        if ($urandom_range(0, 9) < 7) it.post = pick_index(act_post, 32);
      end else if (k < 250) begin
        it.req = REQ_ROW;
        if ($urandom_range(0, 9) < 8) it.pre = pick_index(act_pre + 1, 17);
        k = $urandom_range(0, 9);
        if (k < 7) it.rs = 8*it.pre + $urandom_range(0, 12);
        else if (k < 9) it.rs = $urandom_range(4088, 4100);
      end else if (k < 350) begin
        it.req = REQ_BASIS;
      end else if (k < 750) begin
        it.req = REQ_SPIKE;
        if ($urandom_range(0, 19) < 17) it.pre = pick_index(act_pre, 16);
        if ($urandom_range(0, 9) < 8) it.s = $urandom_range(1, 32767);
        ok = spike_reads_written(it);
      end else if (k < 985) begin
        it.req = REQ_READ;
        if ($urandom_range(0, 9) < 8) it.post = pick_index(act_post, 32);
      end else if (k < 995) begin
        it.req = $urandom_range(0, 1) ? REQ_BAD6 : REQ_BAD7;
      end else begin
        it.req = REQ_CLEAR;
      end
    end
    queue_request(it);
  endtask

  task automatic drain();
    while (request_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    int unsigned x;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    x = (idx == CFG_ACTIVE_BASIS) ? (val & 7) : (val & 11'h7ff);
    if (x < 1) x = 1;
    case (idx)
      CFG_ACTIVE_PRE:  act_pre = (x > N_PRE) ? N_PRE : x;
      CFG_ACTIVE_POST: act_post = (x > N_POST) ? N_POST : x;
      default:         act_basis = (x > N_BASIS) ? N_BASIS : x;
    endcase
  endtask

  task automatic run_phase(int unsigned ap, int unsigned apo, int unsigned ab);
    write_reg(CFG_ACTIVE_PRE, ap);
    write_reg(CFG_ACTIVE_POST, apo);
    write_reg(CFG_ACTIVE_BASIS, ab);
    idle_on = $urandom_range(0, 3) != 0;
    repeat (PER_PHASE) gen_random();
    drain();
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(active_req);
        n_beats++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (request_q.size() > 0) begin
          nxt = request_q.pop_front();
          active_req <= nxt;
          req_type_i <= nxt.req;
          edge_index_i <= nxt.eidx;
          pre_index_i <= nxt.pre;
          post_index_i <= nxt.post;
          syn_type_i <= nxt.styp;
          receptor_i <= nxt.rec;
          batch_index_i <= nxt.bat;
          row_start_i <= nxt.rs;
          weight_value_i <= nxt.w;
          spike_value_i <= nxt.s;
          basis_value_i <= nxt.b;
          start <= 1'b1;
          if (!calm && idle_on && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 5);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat, status", status_o, -1);
      end else begin
        nxt = expected_q.pop_front();
        if (read_value_o !== nxt.exp_val) report_mismatch("read_value", read_value_o, nxt.exp_val);
        if (status_o !== nxt.exp_st) report_mismatch("status", status_o, nxt.exp_st);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout with %0d beats outstanding", expected_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // basis row for type 0, two saturating edges and their rows
    dir(REQ_BASIS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32767);
    dir(REQ_BASIS, 0, 0, 0, 0, 1, 0, 0, 0, 0, -32768);
    dir(REQ_BASIS, 0, 0, 0, 0, 2, 0, 0, 0, 0, 256);
    dir(REQ_BASIS, 0, 0, 0, 0, 3, 0, 0, 0, 0, -1);
    dir(REQ_EDGE, 0, 0, 0, 0, 0, 0, 0, 32767, 0, 0);
    dir(REQ_EDGE, 4095, 0, 1023, 0, 0, 0, 0, -32768, 0, 0);
    dir(REQ_ROW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir(REQ_ROW, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0);
    dir(REQ_ROW, 0, 2, 0, 0, 0, 0, 4095, 0, 0, 0);
    dir(REQ_ROW, 0, 3, 0, 0, 0, 0, 8191, 0, 0, 0);
    dir(REQ_ROW, 0, 1024, 0, 0, 0, 0, 0, 0, 0, 0);
    dir(REQ_ROW, 0, 2047, 0, 0, 0, 0, 0, 0, 0, 0);
    repeat (5) dir(REQ_SPIKE, 0, 0, 0, 0, 0, 3, 0, 0, 32767, 0);
    repeat (5) dir(REQ_SPIKE, 0, 2, 0, 0, 0, 0, 0, 0, 32767, 0);
    dir(REQ_SPIKE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    dir(REQ_SPIKE, 0, 0, 0, 0, 0, 1, 0, 0, -32768, 0);
    dir(REQ_SPIKE, 0, 1024, 0, 0, 0, 1, 0, 0, 1, 0);
    dir(REQ_READ, 0, 0, 0, 0, 0, 3, 0, 0, 0, 0);
    dir(REQ_READ, 0, 0, 1023, 0, 1, 0, 0, 0, 0, 0);
    dir(REQ_BAD6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir(REQ_BAD7, 4095, 2047, 1023, 7, 3, 3, 8191, -1, -1, -1);
    dir(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir(REQ_READ, 0, 0, 1023, 0, 1, 0, 0, 0, 0, 0);
    repeat (PER_PHASE) gen_random();
    drain();
    run_phase(16, 40, 2);
    run_phase(0, 0, 0);
    run_phase(2047, 1, 7);
    run_phase($urandom_range(1, 1024), $urandom_range(1, 1024), $urandom_range(1, 4));
    calm = 1'b1;
    run_phase(1024, 1024, 4);
    repeat (20) @(posedge clk_i);
    $display("covered %0d request beats, %0d result beats, %0d spikes (%0d saturating)",
             n_beats, n_results, n_spikes, n_sat);
    $display("%0d mismatches over %0d cycles", errors, cycles);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
